### src/srt_pkg.sv
// Shared types and constants for the sensor reading table.
// Used by srt_tenths and sensor_reading_table, which sizes srt_ram through the entry width.
package srt_pkg;

    localparam int DEFAULT_SLOTS = 8;

    // Transaction codes
    localparam logic [1:0] OP_RECORD   = 2'd0;
    localparam logic [1:0] OP_READ_POS = 2'd1;
    localparam logic [1:0] OP_READ_ID  = 2'd2;

    // Resolution select in the configuration byte
    localparam logic [7:0] RES_SEL_MASK = 8'h60;
    localparam logic [7:0] RES_SEL_9    = 8'h00;
    localparam logic [7:0] RES_SEL_10   = 8'h20;
    localparam logic [7:0] RES_SEL_11   = 8'h40;

    localparam logic [15:0] RAW_MASK_9  = 16'hFFF8;
    localparam logic [15:0] RAW_MASK_10 = 16'hFFFC;
    localparam logic [15:0] RAW_MASK_11 = 16'hFFFE;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] temp;
        logic [31:0] uptime;
        logic [31:0] wall;
        logic        read_flag;
    } entry_t;

endpackage

### src/sensor_reading_table.sv
// Top level of the sensor reading table: sequencer around one slot RAM.
// Depends on srt_pkg, srt_ram and srt_tenths.
//
// A transaction is taken when start is high and busy is low; busy then stays high
// until the result, which appears for one cycle with done high and must be taken
// then. A record or a read by id walks the occupied slots through the RAM read
// port, one slot per cycle, before the commit; a read by position fetches and
// latches its slot, while a failed position read or an unused opcode goes straight
// to the commit. The next transaction can be started in the cycle done is high.
// The slot RAM needs no clearing after reset; only the state, the fill count, the
// check-valid flag and the done strobe are reset.
module sensor_reading_table #(
    parameter int SLOTS = srt_pkg::DEFAULT_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [15:0]        sensor_id,
    input  logic [7:0]         slot_position,
    input  logic [7:0]         temp_low_byte,
    input  logic [7:0]         temp_high_byte,
    input  logic [7:0]         resolution_byte,
    input  logic [31:0]        uptime_stamp,
    input  logic [31:0]        wall_time,
    output logic               done,
    output logic               ok,
    output logic [2:0]         slot_used,
    output logic               evicted,
    output logic [15:0]        out_sensor_id,
    output logic signed [15:0] temperature_tenths,
    output logic [31:0]        out_uptime_stamp,
    output logic [31:0]        out_wall_time,
    output logic               was_read
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ENTRY_W = $bits(srt_pkg::entry_t);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_LATCH  = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic [CNT_W-1:0] iss_idx_reg, iss_idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [31:0]      best_reg, best_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    srt_pkg::entry_t  hit_entry_reg, hit_entry_next;

    logic [1:0]         op_reg, op_next;
    logic [15:0]        id_reg, id_next;
    logic signed [15:0] temp_reg, temp_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [31:0]        wall_reg, wall_next;

    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [2:0]         slot_used_reg, slot_used_next;
    logic               evicted_reg, evicted_next;
    logic [15:0]        out_id_reg, out_id_next;
    logic signed [15:0] out_temp_reg, out_temp_next;
    logic [31:0]        out_up_reg, out_up_next;
    logic [31:0]        out_wall_reg, out_wall_next;
    logic               was_read_reg, was_read_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    srt_pkg::entry_t    wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    srt_pkg::entry_t    rd_entry;

    logic signed [15:0] tenths;
    logic [31:0]        age;
    logic               accept;
    logic               full;
    logic [IDX_W-1:0]   rec_idx;

    srt_tenths u_tenths (
        .temp_low_byte   (temp_low_byte),
        .temp_high_byte  (temp_high_byte),
        .resolution_byte (resolution_byte),
        .tenths          (tenths)
    );

    srt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = srt_pkg::entry_t'(ram_rdata);
    assign accept   = start && (state_reg == ST_IDLE);
    assign age      = stamp_reg - rd_entry.uptime;
    assign full     = (fill_count_reg == CNT_W'(SLOTS));
    assign ram_raddr = (state_reg == ST_SCAN) ? iss_idx_reg[IDX_W-1:0] : hit_idx_reg;

    always_comb
    begin
        priority if (found_reg)
        begin
            rec_idx = hit_idx_reg;
        end
        else if (!full)
        begin
            rec_idx = fill_count_reg[IDX_W-1:0];
        end
        else
        begin
            rec_idx = best_idx_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        iss_idx_next    = iss_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        hit_entry_next  = hit_entry_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        temp_next       = temp_reg;
        stamp_next      = stamp_reg;
        wall_next       = wall_reg;
        done_next       = 1'b0;
        ok_next         = ok_reg;
        slot_used_next  = slot_used_reg;
        evicted_next    = evicted_reg;
        out_id_next     = out_id_reg;
        out_temp_next   = out_temp_reg;
        out_up_next     = out_up_reg;
        out_wall_next   = out_wall_reg;
        was_read_next   = was_read_reg;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        wr_entry        = hit_entry_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = opcode;
                    id_next       = sensor_id;
                    temp_next     = tenths;
                    stamp_next    = uptime_stamp;
                    wall_next     = wall_time;
                    iss_idx_next  = '0;
                    chk_vld_next  = 1'b0;
                    found_next    = 1'b0;
                    best_next     = '0;
                    best_idx_next = '0;
                    hit_idx_next  = IDX_W'(slot_position);
                    priority if (opcode == srt_pkg::OP_RECORD || opcode == srt_pkg::OP_READ_ID)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (opcode == srt_pkg::OP_READ_POS &&
                             32'(slot_position) < 32'(fill_count_reg))
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one slot read per cycle, check its data in the following cycle
                if (iss_idx_reg < fill_count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_idx_reg[IDX_W-1:0];
                    iss_idx_next = iss_idx_reg + 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end
                if (chk_vld_reg)
                begin
                    if (!found_reg && rd_entry.id == id_reg)
                    begin
                        found_next     = 1'b1;
                        hit_idx_next   = chk_idx_reg;
                        hit_entry_next = rd_entry;
                    end
                    // strict compare keeps the lowest index among equal ages
                    if (best_reg < age)
                    begin
                        best_next     = age;
                        best_idx_next = chk_idx_reg;
                    end
                end
                if (!(iss_idx_reg < fill_count_reg) && !chk_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                found_next     = 1'b1;
                hit_entry_next = rd_entry;
                state_next     = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
                priority if (op_reg == srt_pkg::OP_RECORD)
                begin
                    ram_we             = 1'b1;
                    ram_waddr          = rec_idx;
                    wr_entry.id        = id_reg;
                    wr_entry.temp      = temp_reg;
                    wr_entry.uptime    = stamp_reg;
                    wr_entry.wall      = wall_reg;
                    wr_entry.read_flag = 1'b0;
                    if (!found_reg && !full)
                    begin
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                    ok_next        = 1'b1;
                    slot_used_next = 3'(rec_idx);
                    evicted_next   = !found_reg && full;
                    out_id_next    = id_reg;
                    out_temp_next  = temp_reg;
                    out_up_next    = stamp_reg;
                    out_wall_next  = wall_reg;
                    was_read_next  = 1'b0;
                end
                else if (found_reg)
                begin
                    // set the read flag, hand back the old one
                    ram_we             = 1'b1;
                    ram_waddr          = hit_idx_reg;
                    wr_entry.read_flag = 1'b1;
                    ok_next        = 1'b1;
                    slot_used_next = 3'(hit_idx_reg);
                    evicted_next   = 1'b0;
                    out_id_next    = hit_entry_reg.id;
                    out_temp_next  = hit_entry_reg.temp;
                    out_up_next    = hit_entry_reg.uptime;
                    out_wall_next  = hit_entry_reg.wall;
                    was_read_next  = hit_entry_reg.read_flag;
                end
                else
                begin
                    ok_next        = 1'b0;
                    slot_used_next = '0;
                    evicted_next   = 1'b0;
                    out_id_next    = '0;
                    out_temp_next  = '0;
                    out_up_next    = '0;
                    out_wall_next  = '0;
                    was_read_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            chk_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            chk_vld_reg    <= chk_vld_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_idx_reg   <= iss_idx_next;
        chk_idx_reg   <= chk_idx_next;
        found_reg     <= found_next;
        hit_idx_reg   <= hit_idx_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        hit_entry_reg <= hit_entry_next;
        op_reg        <= op_next;
        id_reg        <= id_next;
        temp_reg      <= temp_next;
        stamp_reg     <= stamp_next;
        wall_reg      <= wall_next;
        ok_reg        <= ok_next;
        slot_used_reg <= slot_used_next;
        evicted_reg   <= evicted_next;
        out_id_reg    <= out_id_next;
        out_temp_reg  <= out_temp_next;
        out_up_reg    <= out_up_next;
        out_wall_reg  <= out_wall_next;
        was_read_reg  <= was_read_next;
    end

    assign busy               = (state_reg != ST_IDLE);
    assign done               = done_reg;
    assign ok                 = ok_reg;
    assign slot_used          = slot_used_reg;
    assign evicted            = evicted_reg;
    assign out_sensor_id      = out_id_reg;
    assign temperature_tenths = out_temp_reg;
    assign out_uptime_stamp   = out_up_reg;
    assign out_wall_time      = out_wall_reg;
    assign was_read           = was_read_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(SLOTS))
        else $error("fill count above slot count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(state_reg == ST_COMMIT))
        else $error("result strobe outside commit");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ok |-> !evicted && !was_read && slot_used == 3'd0 && out_sensor_id == 16'd0)
        else $error("failed transaction returned nonzero fields");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted |-> ok && fill_count_reg == CNT_W'(SLOTS))
        else $error("eviction while table not full");

endmodule

### src/srt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/srt_tenths.sv
// Raw scratchpad temperature to tenths of a degree, with resolution masking.
// Depends on srt_pkg for the resolution constants.
module srt_tenths (
    input  logic [7:0]         temp_low_byte,
    input  logic [7:0]         temp_high_byte,
    input  logic [7:0]         resolution_byte,
    output logic signed [15:0] tenths
);

    logic [15:0]        raw;
    logic [15:0]        masked;
    logic signed [19:0] wide;
    logic signed [19:0] prod;

    assign raw = {temp_high_byte, temp_low_byte};

    always_comb
    begin
        unique case (resolution_byte & srt_pkg::RES_SEL_MASK)
            srt_pkg::RES_SEL_9:  masked = raw & srt_pkg::RAW_MASK_9;
            srt_pkg::RES_SEL_10: masked = raw & srt_pkg::RAW_MASK_10;
            srt_pkg::RES_SEL_11: masked = raw & srt_pkg::RAW_MASK_11;
            default:             masked = raw;
        endcase
    end

    // times ten as 8x + 2x; the arithmetic shift right by 4 rounds toward minus infinity
    assign wide   = {{4{masked[15]}}, masked};
    assign prod   = (wide <<< 3) + (wide <<< 1);
    assign tenths = prod[19:4];

endmodule

### bench/srt_checker.sv
`timescale 1ns / 100ps
// Transaction checker for the sensor reading table: watches the start/busy and done
// channels, predicts each result from its own copy of the slot table, and compares.
// Depends on srt_pkg for transaction codes and resolution masks.
module srt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] sensor_id,
    input  logic [7:0]  slot_position,
    input  logic [7:0]  temp_low_byte,
    input  logic [7:0]  temp_high_byte,
    input  logic [7:0]  resolution_byte,
    input  logic [31:0] uptime_stamp,
    input  logic [31:0] wall_time,
    input  logic        done,
    input  logic        ok,
    input  logic [2:0]  slot_used,
    input  logic        evicted,
    input  logic [15:0] out_sensor_id,
    input  logic [15:0] temperature_tenths,
    input  logic [31:0] out_uptime_stamp,
    input  logic [31:0] out_wall_time,
    input  logic        was_read,
    output int          mismatch_count,
    output int          pending_results,
    output int          results_checked,
    output int          evictions_predicted
);

    localparam int SLOTS = srt_pkg::DEFAULT_SLOTS;

    typedef struct packed {
        logic        ok;
        logic [2:0]  slot;
        logic        evicted;
        logic [15:0] id;
        logic [15:0] tenths;
        logic [31:0] uptime;
        logic [31:0] wall;
        logic        was_read;
    } reading_result_t;

    // Predicted copy of the slot table
    logic [15:0] table_ids        [SLOTS];
    logic [15:0] table_tenths     [SLOTS];
    logic [31:0] table_uptimes    [SLOTS];
    logic [31:0] table_walls      [SLOTS];
    logic        table_read_flags [SLOTS];
    int          table_fill;

    reading_result_t expected_readings [$];
    reading_result_t want;
    reading_result_t got;
    int              mismatches;
    int              checked;
    int              evictions;

    function automatic logic [15:0] tenths_from_scratchpad(
        input logic [7:0] lo,
        input logic [7:0] hi,
        input logic [7:0] res
    );
        logic [15:0]        raw;
        logic signed [31:0] scaled;
        raw = {hi, lo};
        case (res & srt_pkg::RES_SEL_MASK)
            srt_pkg::RES_SEL_9:  raw = raw & srt_pkg::RAW_MASK_9;
            srt_pkg::RES_SEL_10: raw = raw & srt_pkg::RAW_MASK_10;
            srt_pkg::RES_SEL_11: raw = raw & srt_pkg::RAW_MASK_11;
            default:             raw = raw;
        endcase
        scaled = $signed({{16{raw[15]}}, raw}) * 32'sd10;
        // arithmetic shift gives floor division by 16
        scaled = scaled >>> 4;
        return scaled[15:0];
    endfunction

    function automatic reading_result_t slot_contents(input int idx, input logic ev,
                                                      input logic was);
        reading_result_t r;
        r.ok       = 1'b1;
        r.slot     = idx[2:0];
        r.evicted  = ev;
        r.id       = table_ids[idx];
        r.tenths   = table_tenths[idx];
        r.uptime   = table_uptimes[idx];
        r.wall     = table_walls[idx];
        r.was_read = was;
        return r;
    endfunction

    task automatic predict_reading_result(output reading_result_t r);
        int          idx;
        int          i;
        logic        found;
        logic        ev;
        logic [31:0] best;
        logic [31:0] age;
        r     = '0;
        idx   = -1;
        found = 1'b0;
        ev    = 1'b0;
        case (opcode)
            srt_pkg::OP_RECORD:
            begin
                for (i = 0; i < table_fill && !found; i++)
                    if (table_ids[i] == sensor_id)
                    begin
                        idx   = i;
                        found = 1'b1;
                    end
                if (!found)
                begin
                    if (table_fill < SLOTS)
                    begin
                        idx = table_fill;
                        table_fill++;
                    end
                    else
                    begin
                        // evict the stamp furthest back; zero ages everywhere picks slot 0
                        best = '0;
                        idx  = 0;
                        for (i = 0; i < SLOTS; i++)
                        begin
                            age = uptime_stamp - table_uptimes[i];
                            if (best < age)
                            begin
                                best = age;
                                idx  = i;
                            end
                        end
                        ev = 1'b1;
                        evictions++;
                    end
                end
                table_ids[idx]        = sensor_id;
                table_tenths[idx]     = tenths_from_scratchpad(temp_low_byte, temp_high_byte,
                                                               resolution_byte);
                table_uptimes[idx]    = uptime_stamp;
                table_walls[idx]      = wall_time;
                table_read_flags[idx] = 1'b0;
                r = slot_contents(idx, ev, 1'b0);
            end
            srt_pkg::OP_READ_POS:
            begin
                if (int'(slot_position) < table_fill) idx = int'(slot_position);
            end
            srt_pkg::OP_READ_ID:
            begin
                for (i = 0; i < table_fill && idx < 0; i++)
                    if (table_ids[i] == sensor_id) idx = i;
            end
            default: ;
        endcase
        if ((opcode == srt_pkg::OP_READ_POS || opcode == srt_pkg::OP_READ_ID) && idx >= 0)
        begin
            r = slot_contents(idx, 1'b0, table_read_flags[idx]);
            table_read_flags[idx] = 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected 0x%0h, got 0x%0h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_fill = 0;
            expected_readings.delete();
            mismatches = 0;
            checked    = 0;
            evictions  = 0;
            mismatch_count      <= 0;
            pending_results     <= 0;
            results_checked     <= 0;
            evictions_predicted <= 0;
        end
        else
        begin
            // retire the finished transaction before taking the next one
            if (done)
            begin
                got = '{ok, slot_used, evicted, out_sensor_id, temperature_tenths,
                        out_uptime_stamp, out_wall_time, was_read};
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with no transaction outstanding", $realtime);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compare_field("ok", want.ok, got.ok);
                    compare_field("slot_used", want.slot, got.slot);
                    compare_field("evicted", want.evicted, got.evicted);
                    compare_field("out_sensor_id", want.id, got.id);
                    compare_field("temperature_tenths", want.tenths, got.tenths);
                    compare_field("out_uptime_stamp", want.uptime, got.uptime);
                    compare_field("out_wall_time", want.wall, got.wall);
                    compare_field("was_read", want.was_read, got.was_read);
                    checked++;
                end
            end
            if (start && !busy)
            begin
                predict_reading_result(want);
                expected_readings.push_back(want);
            end
            mismatch_count      <= mismatches;
            pending_results     <= expected_readings.size();
            results_checked     <= checked;
            evictions_predicted <= evictions;
        end
    end

endmodule

### bench/sensor_reading_table_tb.sv
`timescale 1ns / 100ps
// Top of the sensor reading table testbench: clock, reset and transaction stimulus.
// Depends on srt_pkg, the sensor_reading_table RTL and the srt_checker module.
module sensor_reading_table_tb;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         LIMIT_CYCLES = 300000;
    localparam int         PHASE_ITEMS  = 200;
    localparam int         ID_POOL      = 12;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic [1:0]  opcode          = '0;
    logic [15:0] sensor_id       = '0;
    logic [7:0]  slot_position   = '0;
    logic [7:0]  temp_low_byte   = '0;
    logic [7:0]  temp_high_byte  = '0;
    logic [7:0]  resolution_byte = '0;
    logic [31:0] uptime_stamp    = '0;
    logic [31:0] wall_time       = '0;

    logic               busy;
    logic               done;
    logic               ok;
    logic [2:0]         slot_used;
    logic               evicted;
    logic [15:0]        out_sensor_id;
    logic signed [15:0] temperature_tenths;
    logic [31:0]        out_uptime_stamp;
    logic [31:0]        out_wall_time;
    logic               was_read;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int evictions_predicted;

    int          records_sent;
    int          pos_reads_sent;
    int          id_reads_sent;
    int          unused_sent;
    logic [15:0] id_pool [ID_POOL];
    logic [31:0] now_stamp;

    sensor_reading_table u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .opcode             (opcode),
        .sensor_id          (sensor_id),
        .slot_position      (slot_position),
        .temp_low_byte      (temp_low_byte),
        .temp_high_byte     (temp_high_byte),
        .resolution_byte    (resolution_byte),
        .uptime_stamp       (uptime_stamp),
        .wall_time          (wall_time),
        .done               (done),
        .ok                 (ok),
        .slot_used          (slot_used),
        .evicted            (evicted),
        .out_sensor_id      (out_sensor_id),
        .temperature_tenths (temperature_tenths),
        .out_uptime_stamp   (out_uptime_stamp),
        .out_wall_time      (out_wall_time),
        .was_read           (was_read)
    );

    srt_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .opcode              (opcode),
        .sensor_id           (sensor_id),
        .slot_position       (slot_position),
        .temp_low_byte       (temp_low_byte),
        .temp_high_byte      (temp_high_byte),
        .resolution_byte     (resolution_byte),
        .uptime_stamp        (uptime_stamp),
        .wall_time           (wall_time),
        .done                (done),
        .ok                  (ok),
        .slot_used           (slot_used),
        .evicted             (evicted),
        .out_sensor_id       (out_sensor_id),
        .temperature_tenths  (temperature_tenths),
        .out_uptime_stamp    (out_uptime_stamp),
        .out_wall_time       (out_wall_time),
        .was_read            (was_read),
        .mismatch_count      (mismatch_count),
        .pending_results     (pending_results),
        .results_checked     (results_checked),
        .evictions_predicted (evictions_predicted)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("Timeout after %0d cycles", LIMIT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

    // Hold the transaction on the ports until it is taken.
    task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                             input logic [7:0] pos, input logic [7:0] lo,
                             input logic [7:0] hi, input logic [7:0] res,
                             input logic [31:0] up, input logic [31:0] wall);
        opcode          <= op;
        sensor_id       <= id;
        slot_position   <= pos;
        temp_low_byte   <= lo;
        temp_high_byte  <= hi;
        resolution_byte <= res;
        uptime_stamp    <= up;
        wall_time       <= wall;
        start           <= 1'b1;
        do @(posedge clk); while (busy);
        case (op)
            srt_pkg::OP_RECORD:   records_sent++;
            srt_pkg::OP_READ_POS: pos_reads_sent++;
            srt_pkg::OP_READ_ID:  id_reads_sent++;
            default:              unused_sent++;
        endcase
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending until every outstanding transaction has returned.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
    endtask

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic record_item(input logic [15:0] id, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] res,
                               input logic [31:0] up, input logic [31:0] wall);
        send_item(srt_pkg::OP_RECORD, id, 8'($urandom), lo, hi, res, up, wall);
        pause(random_gap());
    endtask

    task automatic read_item(input logic [1:0] op, input logic [15:0] id,
                             input logic [7:0] pos);
        send_item(op, id, pos, 8'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
        pause(random_gap());
    endtask

    task automatic send_random_item(input logic with_gaps);
        int          r;
        logic [1:0]  op;
        logic [15:0] id;
        logic [7:0]  pos;
        logic [31:0] up;
        r   = $urandom_range(0, 99);
        op  = (r < 45) ? srt_pkg::OP_RECORD :
              (r < 70) ? srt_pkg::OP_READ_POS :
              (r < 96) ? srt_pkg::OP_READ_ID : OP_UNUSED;
        id  = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, ID_POOL - 1)]
                                         : 16'($urandom);
        pos = ($urandom_range(0, 4) < 4) ? 8'($urandom_range(0, 9)) : 8'($urandom);
        // mostly advancing stamps, now and then an arbitrary one
        now_stamp = now_stamp + $urandom_range(0, 2000);
        up  = ($urandom_range(0, 9) == 0) ? $urandom : now_stamp;
        send_item(op, id, pos, 8'($urandom), 8'($urandom), 8'($urandom), up, $urandom);
        if (with_gaps) pause(random_gap());
    endtask

    initial
    begin
        int k;
        records_sent   = 0;
        pos_reads_sent = 0;
        id_reads_sent  = 0;
        unused_sent    = 0;
        for (k = 0; k < ID_POOL; k++) id_pool[k] = 16'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: failed reads and the unused opcode
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd0);
        read_item(srt_pkg::OP_READ_ID, 16'h1234, 8'd0);
        read_item(OP_UNUSED, 16'h0000, 8'd0);

        // fill every slot with one stamp, covering the resolution selects and raw extremes
        record_item(16'h0000, 8'h00, 8'h00, 8'h00, 32'h8000_0000, 32'h0000_0000);
        record_item(16'hFFFF, 8'hFF, 8'h7F, 8'h60, 32'h8000_0000, 32'hFFFF_FFFF);
        record_item(16'h0001, 8'h00, 8'h80, 8'h60, 32'h8000_0000, $urandom);
        record_item(16'h8000, 8'hFF, 8'hFF, 8'h00, 32'h8000_0000, $urandom);
        record_item(16'h7FFF, 8'hFF, 8'hFF, 8'h20, 32'h8000_0000, $urandom);
        record_item(16'h00FF, 8'hFF, 8'hFF, 8'h40, 32'h8000_0000, $urandom);
        record_item(16'hFF00, 8'hFF, 8'h7F, 8'h9F, 32'h8000_0000, $urandom);
        record_item(16'h5A5A, 8'h91, 8'h01, 8'hFF, 32'h8000_0000, $urandom);
        // all ages zero: slot 0 goes
        record_item(16'hA5A5, 8'h50, 8'h01, 8'h60, 32'h8000_0000, $urandom);
        // update in place, with the oldest stamp in the table
        record_item(16'h8000, 8'h0F, 8'hFE, 8'h60, 32'h0000_0000, $urandom);
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd0);
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd0);
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd7);
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd8);
        read_item(srt_pkg::OP_READ_POS, 16'h0000, 8'd255);
        read_item(srt_pkg::OP_READ_ID, 16'hFFFF, 8'd0);
        read_item(srt_pkg::OP_READ_ID, 16'hBEEF, 8'd0);
        // oldest stamp across the wrap evicts the updated slot
        record_item(16'h1234, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF, $urandom);
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        drain();

        // random traffic with idle gaps
        now_stamp = $urandom;
        for (k = 0; k < PHASE_ITEMS; k++) send_random_item(1'b1);
        drain();

        // back to back
        for (k = 0; k < PHASE_ITEMS; k++) send_random_item(1'b0);
        drain();

        // stamps starting close below the 32-bit wrap
        now_stamp = 32'hFFFC_0000;
        for (k = 0; k < PHASE_ITEMS; k++) send_random_item(1'b1);
        drain();

        repeat (20) @(posedge clk);
        $display("Sent %0d records, %0d position reads, %0d id reads, %0d unused opcodes",
                 records_sent, pos_reads_sent, id_reads_sent, unused_sent);
        $display("Checked %0d results including %0d predicted evictions",
                 results_checked, evictions_predicted);
        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
